/* design/scs1a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 decoder package
// Codes, lookup tables and shared types for the set 1 scan code decoder.
// ----------------------------------------------------------------------------
package scs1a_pkg;

  localparam logic [7:0] CodePrefix   = 8'hE0;
  localparam logic [6:0] CodeLShift   = 7'h2A;
  localparam logic [6:0] CodeRShift   = 7'h36;
  localparam logic [7:0] CodePageUp   = 8'h49;
  localparam logic [7:0] CodePageDown = 8'h51;
  localparam logic [5:0] MapSize      = 6'h3A;

  typedef enum logic [1:0] {
    PAGE_NONE = 2'd0,
    PAGE_UP   = 2'd1,
    PAGE_DOWN = 2'd2
  } page_e;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    page_e      page_request;
    logic       shift_d;
    logic       prefix_d;
  } decode_t;

  function automatic logic [6:0] plain_char(input logic [5:0] idx);
    logic [6:0] ch;
    unique case (idx)
      6'h01:   ch = 7'h1B;
      6'h02:   ch = 7'h31;
      6'h03:   ch = 7'h32;
      6'h04:   ch = 7'h33;
      6'h05:   ch = 7'h34;
      6'h06:   ch = 7'h35;
      6'h07:   ch = 7'h36;
      6'h08:   ch = 7'h37;
      6'h09:   ch = 7'h38;
      6'h0A:   ch = 7'h39;
      6'h0B:   ch = 7'h30;
      6'h0C:   ch = 7'h2D;
      6'h0E:   ch = 7'h08;
      6'h10:   ch = 7'h71;
      6'h11:   ch = 7'h77;
      6'h12:   ch = 7'h65;
      6'h13:   ch = 7'h72;
      6'h14:   ch = 7'h74;
      6'h15:   ch = 7'h79;
      6'h16:   ch = 7'h75;
      6'h17:   ch = 7'h69;
      6'h18:   ch = 7'h6F;
      6'h19:   ch = 7'h70;
      6'h1C:   ch = 7'h0A;
      6'h1E:   ch = 7'h61;
      6'h1F:   ch = 7'h73;
      6'h20:   ch = 7'h64;
      6'h21:   ch = 7'h66;
      6'h22:   ch = 7'h67;
      6'h23:   ch = 7'h68;
      6'h24:   ch = 7'h6A;
      6'h25:   ch = 7'h6B;
      6'h26:   ch = 7'h6C;
      6'h2C:   ch = 7'h7A;
      6'h2D:   ch = 7'h78;
      6'h2E:   ch = 7'h63;
      6'h2F:   ch = 7'h76;
      6'h30:   ch = 7'h62;
      6'h31:   ch = 7'h6E;
      6'h32:   ch = 7'h6D;
      6'h34:   ch = 7'h2E;
      6'h39:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [5:0] idx);
    logic [6:0] ch;
    unique case (idx)
      6'h01:   ch = 7'h1B;
      6'h02:   ch = 7'h21;
      6'h03:   ch = 7'h40;
      6'h04:   ch = 7'h23;
      6'h05:   ch = 7'h24;
      6'h06:   ch = 7'h25;
      6'h07:   ch = 7'h5E;
      6'h08:   ch = 7'h26;
      6'h09:   ch = 7'h2A;
      6'h0A:   ch = 7'h28;
      6'h0B:   ch = 7'h29;
      6'h0C:   ch = 7'h5F;
      6'h0E:   ch = 7'h08;
      6'h10:   ch = 7'h51;
      6'h11:   ch = 7'h57;
      6'h12:   ch = 7'h45;
      6'h13:   ch = 7'h52;
      6'h14:   ch = 7'h54;
      6'h15:   ch = 7'h59;
      6'h16:   ch = 7'h55;
      6'h17:   ch = 7'h49;
      6'h18:   ch = 7'h4F;
      6'h19:   ch = 7'h50;
      6'h1C:   ch = 7'h0A;
      6'h1E:   ch = 7'h41;
      6'h1F:   ch = 7'h53;
      6'h20:   ch = 7'h44;
      6'h21:   ch = 7'h46;
      6'h22:   ch = 7'h47;
      6'h23:   ch = 7'h48;
      6'h24:   ch = 7'h4A;
      6'h25:   ch = 7'h4B;
      6'h26:   ch = 7'h4C;
      6'h2C:   ch = 7'h5A;
      6'h2D:   ch = 7'h58;
      6'h2E:   ch = 7'h43;
      6'h2F:   ch = 7'h56;
      6'h30:   ch = 7'h42;
      6'h31:   ch = 7'h4E;
      6'h32:   ch = 7'h4D;
      6'h34:   ch = 7'h3E;
      6'h39:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

/* design/scs1a_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 byte decoder
// Decodes one scan byte against the current shift and prefix flags and gives
// the result fields together with the next values of both flags.
// ----------------------------------------------------------------------------
module scs1a_decode import scs1a_pkg::*; (
  input  logic [7:0] scan_byte_i,
  input  logic       shift_i,
  input  logic       prefix_i,
  output decode_t    dec_o
);

  logic [6:0] ch;
  page_e      page;
  logic       shift_d;
  logic       prefix_d;

  always_comb begin
    ch       = 7'h00;
    page     = PAGE_NONE;
    shift_d  = shift_i;
    prefix_d = prefix_i;
    priority if (scan_byte_i == CodePrefix) begin
      prefix_d = 1'b1;
    end else if (prefix_i) begin
      prefix_d = 1'b0;
      if (scan_byte_i == CodePageUp) begin
        page = PAGE_UP;
      end else if (scan_byte_i == CodePageDown) begin
        page = PAGE_DOWN;
      end
    end else if (scan_byte_i[7]) begin
      if (scan_byte_i[6:0] == CodeLShift || scan_byte_i[6:0] == CodeRShift) begin
        shift_d = 1'b0;
      end
    end else if (scan_byte_i[6:0] == CodeLShift || scan_byte_i[6:0] == CodeRShift) begin
      shift_d = 1'b1;
    end else begin
      if (scan_byte_i[6] == 1'b0 && scan_byte_i[5:0] < MapSize) begin
        ch = shift_i ? shifted_char(scan_byte_i[5:0]) : plain_char(scan_byte_i[5:0]);
      end
    end
  end

  assign dec_o.char_valid   = (ch != 7'h00);
  assign dec_o.char_code    = ch;
  assign dec_o.page_request = page;
  assign dec_o.shift_d      = shift_d;
  assign dec_o.prefix_d     = prefix_d;

endmodule

/* design/scancode_set1_to_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 to ASCII unit
// Turns received keyboard scan bytes into ASCII characters and page requests.
// ----------------------------------------------------------------------------
// The unit takes one scan byte per cycle when in_stall_o is low and gives
// exactly one result item for each byte. Each byte is held in the input
// register and then in the result register, with the table lookup and flag
// update in between. The shift and prefix flags are updated as each item moves
// into the result register, so consecutive bytes decode in order at full rate.
// A stalled output holds its item while the input register still accepts one
// further byte.
module scancode_set1_to_ascii_unit import scs1a_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o,
  output logic [1:0] page_request_o
);

  logic       in_valid_q;
  logic [7:0] scan_byte_q;
  logic       out_valid_q;
  logic       char_valid_q;
  logic [6:0] char_code_q;
  logic [1:0] page_request_q;
  logic       shift_q;
  logic       prefix_q;
  logic       advance;
  logic       load;
  decode_t    dec;

  scs1a_decode u_decode (
    .scan_byte_i (scan_byte_q),
    .shift_i     (shift_q),
    .prefix_i    (prefix_q),
    .dec_o       (dec)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      shift_q     <= 1'b0;
      prefix_q    <= 1'b0;
    end else begin
      if (load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        shift_q     <= dec.shift_d;
        prefix_q    <= dec.prefix_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      scan_byte_q <= scan_byte_i;
    end
    if (advance) begin
      char_valid_q   <= dec.char_valid;
      char_code_q    <= dec.char_code;
      page_request_q <= dec.page_request;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_valid_o   = char_valid_q;
  assign char_code_o    = char_code_q;
  assign page_request_o = page_request_q;

endmodule

/* design/scs1a_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 decoder checker
// Port-level checks on the result items of the scan code unit.
// ----------------------------------------------------------------------------
module scs1a_port_checks import scs1a_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       char_valid_o,
  input logic [6:0] char_code_o,
  input logic [1:0] page_request_o
);

  // A character item carries a non-zero code and no page request.
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && char_valid_o) |-> (char_code_o != 7'h00 && page_request_o == PAGE_NONE))
    else $error("character item with zero code or page request");

  // An item without a character carries a zero code.
  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !char_valid_o) |-> (char_code_o == 7'h00))
    else $error("non-character item with non-zero code");

  // Only the defined page request codes appear.
  a_page_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (page_request_o == PAGE_NONE || page_request_o == PAGE_UP ||
                     page_request_o == PAGE_DOWN))
    else $error("undefined page request code");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(char_valid_o) &&
                                      $stable(char_code_o) && $stable(page_request_o)))
    else $error("stalled result item changed");

  // The input only stalls behind a stalled result item.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result item");

endmodule

bind scancode_set1_to_ascii_unit scs1a_port_checks u_scs1a_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .char_valid_o   (char_valid_o),
  .char_code_o    (char_code_o),
  .page_request_o (page_request_o)
);

/* tb/scs1a_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code decoder checker
// Watches both channels of the scan code unit. It decodes every accepted scan
// byte with its own model of the shift and prefix flags, queues the expected
// result and compares each result item from the unit with the oldest entry.
// ----------------------------------------------------------------------------
module scs1a_checker import scs1a_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] scan_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       char_valid_i,
  input  logic [6:0] char_code_i,
  input  logic [1:0] page_request_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [7:0] AsciiBackspace = 8'd8;
  localparam logic [7:0] AsciiEnter     = 8'd10;
  localparam logic [7:0] AsciiEscape    = 8'd27;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    page_e      page;
  } key_result_t;

  key_result_t expected_keys[$];
  logic        shift_flag;
  logic        prefix_armed;
  int          bytes_seen;
  int          keys_checked;
  int          errors;

  assign pending_o    = bytes_seen - keys_checked;
  assign fail_count_o = errors;

  function automatic logic [7:0] key_ascii(input logic [7:0] code, input logic shifted);
    logic [7:0] ch;
    case (code)
      8'h01:   ch = AsciiEscape;
      8'h02:   ch = shifted ? "!" : "1";
      8'h03:   ch = shifted ? "@" : "2";
      8'h04:   ch = shifted ? "#" : "3";
      8'h05:   ch = shifted ? "$" : "4";
      8'h06:   ch = shifted ? "%" : "5";
      8'h07:   ch = shifted ? "^" : "6";
      8'h08:   ch = shifted ? "&" : "7";
      8'h09:   ch = shifted ? "*" : "8";
      8'h0A:   ch = shifted ? "(" : "9";
      8'h0B:   ch = shifted ? ")" : "0";
      8'h0C:   ch = shifted ? "_" : "-";
      8'h0E:   ch = AsciiBackspace;
      8'h10:   ch = "q";
      8'h11:   ch = "w";
      8'h12:   ch = "e";
      8'h13:   ch = "r";
      8'h14:   ch = "t";
      8'h15:   ch = "y";
      8'h16:   ch = "u";
      8'h17:   ch = "i";
      8'h18:   ch = "o";
      8'h19:   ch = "p";
      8'h1C:   ch = AsciiEnter;
      8'h1E:   ch = "a";
      8'h1F:   ch = "s";
      8'h20:   ch = "d";
      8'h21:   ch = "f";
      8'h22:   ch = "g";
      8'h23:   ch = "h";
      8'h24:   ch = "j";
      8'h25:   ch = "k";
      8'h26:   ch = "l";
      8'h2C:   ch = "z";
      8'h2D:   ch = "x";
      8'h2E:   ch = "c";
      8'h2F:   ch = "v";
      8'h30:   ch = "b";
      8'h31:   ch = "n";
      8'h32:   ch = "m";
      8'h34:   ch = shifted ? ">" : ".";
      8'h39:   ch = " ";
      default: ch = 8'h00;
    endcase
    if (shifted && ch >= "a" && ch <= "z") begin
      ch = ch - 8'h20;
    end
    return ch;
  endfunction

  function automatic key_result_t decode_scan_byte(input logic [7:0] code);
    key_result_t res;
    logic [7:0]  ch;
    res = '{char_valid: 1'b0, char_code: 7'd0, page: PAGE_NONE};
    if (code == CodePrefix) begin
      prefix_armed = 1'b1;
    end else if (prefix_armed) begin
      prefix_armed = 1'b0;
      if (code == CodePageUp) begin
        res.page = PAGE_UP;
      end else if (code == CodePageDown) begin
        res.page = PAGE_DOWN;
      end
    end else if (code[7]) begin
      if (code[6:0] == CodeLShift || code[6:0] == CodeRShift) begin
        shift_flag = 1'b0;
      end
    end else if (code[6:0] == CodeLShift || code[6:0] == CodeRShift) begin
      shift_flag = 1'b1;
    end else begin
      ch             = key_ascii(code, shift_flag);
      res.char_code  = ch[6:0];
      res.char_valid = (ch != 8'h00);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    if (!rst_ni) begin
      expected_keys.delete();
      shift_flag   = 1'b0;
      prefix_armed = 1'b0;
      bytes_seen   <= 0;
      keys_checked <= 0;
      errors       = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_keys.push_back(decode_scan_byte(scan_byte_i));
        bytes_seen <= bytes_seen + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_keys.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected result item: char_valid %0b char_code %h page %0d",
                     $realtime, char_valid_i, char_code_i, page_request_i);
          end
          errors++;
        end else begin
          want = expected_keys.pop_front();
          keys_checked <= keys_checked + 1;
          if (char_valid_i !== want.char_valid || char_code_i !== want.char_code ||
              page_request_i !== want.page) begin
            if (errors < 10) begin
              $display({"%0t: mismatch: expected char_valid %0b char_code %h page %0d,",
                        " got %0b %h %0d"},
                       $realtime, want.char_valid, want.char_code, want.page,
                       char_valid_i, char_code_i, page_request_i);
            end
            errors++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_scancode_set1_to_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 to ASCII unit testbench
// Drives directed scan byte sequences and then random typing, with shifted
// bursts, extended page keys and noise, under random idling on both sides.
// A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_scancode_set1_to_ascii_unit import scs1a_pkg::*;;

  localparam int RandomBytes = 1850;
  localparam int IdleLimit   = 1000;
  localparam int DrainStep   = 400;

  localparam logic [7:0] DirectedBytes [26] = '{
    8'h00, 8'hFF, 8'hE0, 8'hE0, 8'h49, 8'hE0, 8'h51, 8'h10, 8'h2A, 8'hE0,
    8'hAA, 8'h10, 8'h34, 8'hAA, 8'hE0, 8'h2A, 8'h10, 8'h36, 8'h02, 8'h9E,
    8'hB6, 8'h39, 8'h1C, 8'h0E, 8'h01, 8'h49
  };

  logic       clk_i;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] scan_byte  = 8'h00;
  logic       out_stall  = 1'b0;
  logic       quiet      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       char_valid;
  logic [6:0] char_code;
  logic [1:0] page_request;
  int         fail_count;
  int         pending;
  int         bytes_sent = 0;
  int         idle_cycles = 0;

  scancode_set1_to_ascii_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .scan_byte_i    (scan_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .char_valid_o   (char_valid),
    .char_code_o    (char_code),
    .page_request_o (page_request)
  );

  scs1a_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .scan_byte_i    (scan_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .char_valid_i   (char_valid),
    .char_code_i    (char_code),
    .page_request_i (page_request),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_scan(input logic [7:0] code);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    scan_byte <= code;
    do @(posedge clk_i); while (in_stall);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int         pick;
    int         next_drain;
    logic [7:0] code;
    logic [6:0] shift_code;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedBytes[i]) begin
      send_scan(DirectedBytes[i]);
    end
    wait_for_results();

    bytes_sent = 0;
    next_drain = DrainStep;
    while (bytes_sent < RandomBytes) begin
      quiet <= (bytes_sent >= 700 && bytes_sent < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        code = 8'($urandom_range(1, 8'h39));
        send_scan(code);
        if ($urandom_range(0, 1) == 1) begin
          send_scan(code | 8'h80);
        end
      end else if (pick < 55) begin
        shift_code = ($urandom_range(0, 1) == 1) ? CodeLShift : CodeRShift;
        send_scan({1'b0, shift_code});
        repeat ($urandom_range(1, 6)) send_scan(8'($urandom_range(1, 8'h39)));
        if ($urandom_range(0, 3) != 0) begin
          send_scan({1'b1, shift_code});
        end
      end else if (pick < 72) begin
        send_scan(CodePrefix);
        case ($urandom_range(0, 5))
          0, 1:    send_scan(CodePageUp);
          2, 3:    send_scan(CodePageDown);
          4:       send_scan(($urandom_range(0, 1) == 1) ? (CodePageUp | 8'h80)
                                                          : (CodePageDown | 8'h80));
          default: send_scan(8'($urandom_range(0, 255)));
        endcase
      end else begin
        send_scan(8'($urandom_range(0, 255)));
      end
      if (bytes_sent >= next_drain) begin
        wait_for_results();
        next_drain += DrainStep;
      end
    end
    quiet <= 1'b0;

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/scs1a_pkg.sv
design/scs1a_decode.sv
design/scancode_set1_to_ascii_unit.sv
design/scs1a_checker.sv
tb/scs1a_checker.sv
tb/tb_scancode_set1_to_ascii_unit.sv
